// File: hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the bounded deque controller and datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned CAP_W  = 5;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] EMPTY_MARK = 32'hFFFF_FFFF;

  // Request codes carried in the low bits of the input word.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_QUERY      = 3'd4
  } req_e;

  // Ring operation applied by the datapath.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the input word
    logic exec;      // apply op and latch ok
    op_e  op;
    logic ok;
    logic read;      // read front and rear slots
    logic load_out;  // fill the output register
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             full;
    logic             empty;
    logic             out_free;
  } dq_status_t;

endpackage

// File: hdl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer for one request: capture, update the ring, read, hand over.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  dq_pkg::dq_status_t status_i,
  output dq_pkg::dq_cmd_t    cmd_o
);
  import dq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_LOAD
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.op        = OP_NONE;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        case (req_e'(status_i.req))
          REQ_PUSH_FRONT: begin
            cmd_o.ok = !status_i.full;
            cmd_o.op = status_i.full ? OP_NONE : OP_PUSH_FRONT;
          end
          REQ_PUSH_BACK: begin
            cmd_o.ok = !status_i.full;
            cmd_o.op = status_i.full ? OP_NONE : OP_PUSH_BACK;
          end
          REQ_POP_FRONT: begin
            cmd_o.ok = !status_i.empty;
            cmd_o.op = status_i.empty ? OP_NONE : OP_POP_FRONT;
          end
          REQ_POP_BACK: begin
            cmd_o.ok = !status_i.empty;
            cmd_o.op = status_i.empty ? OP_NONE : OP_POP_BACK;
          end
          REQ_QUERY: begin
            cmd_o.ok = 1'b1;
          end
          default: begin
            cmd_o.ok = 1'b0;
          end
        endcase
        state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Ring storage with head index and count, capacity register, output register.
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int unsigned MAX_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dq_pkg::CAP_W-1:0]       cfg_wdata_i,
  input  logic [dq_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [dq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  dq_pkg::dq_cmd_t                cmd_i,
  output dq_pkg::dq_status_t             status_o
);
  import dq_pkg::*;

  localparam int unsigned IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [IDX_W:0]   DEPTH_V = (IDX_W + 1)'(MAX_DEPTH);
  localparam logic [IDX_W-1:0] LAST_V  = IDX_W'(MAX_DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(MAX_DEPTH);

  logic [DATA_W-1:0] slots [MAX_DEPTH];

  logic [CAP_W-1:0]  cap_q;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [REQ_W-1:0]  req_q;
  logic [DATA_W-1:0] value_q;
  logic              ok_q;
  logic [DATA_W-1:0] front_rd_q, rear_rd_q;
  logic              out_valid_q;
  logic [OUT_TDATA_W-1:0] out_q;

  logic [CMP_W-1:0]  eff_cap, count_ext;
  logic              full, empty;
  logic [IDX_W-1:0]  head_dec, head_inc, back_idx, rear_idx;
  logic [CNT_W-1:0]  count_m1;

  // Ring position of head plus offset, offset below the depth.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= DEPTH_V) begin
      sum = sum - DEPTH_V;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign eff_cap   = (CMP_W'(cap_q) > DEPTH_C) ? DEPTH_C :
                     CMP_W'(cap_q);
  assign count_ext = CMP_W'(count_q);
  assign full      = count_ext >= eff_cap;
  assign empty     = (count_q == '0);
  assign count_m1  = count_q - 1'b1;

  assign head_dec = (head_q == '0) ? LAST_V : head_q - 1'b1;
  assign head_inc = ring_add(head_q, IDX_W'(1));
  assign back_idx = ring_add(head_q, IDX_W'(count_q));
  assign rear_idx = ring_add(head_q, IDX_W'(count_m1));

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.exec) begin
      case (cmd_i.op)
        OP_PUSH_FRONT: begin
          head_d  = head_dec;
          count_d = count_q + 1'b1;
        end
        OP_PUSH_BACK: begin
          count_d = count_q + 1'b1;
        end
        OP_POP_FRONT: begin
          head_d  = head_inc;
          count_d = count_m1;
        end
        OP_POP_BACK: begin
          count_d = count_m1;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      head_q  <= head_d;
      count_q <= count_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Slot writes and the two slot reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && cmd_i.op == OP_PUSH_FRONT) begin
      slots[head_dec] <= value_q;
    end else if (cmd_i.exec && cmd_i.op == OP_PUSH_BACK) begin
      slots[back_idx] <= value_q;
    end
    if (cmd_i.read) begin
      front_rd_q <= slots[head_q];
      rear_rd_q  <= slots[rear_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= s_axis_tdata_i[REQ_W-1:0];
      value_q <= s_axis_tdata_i[REQ_W+DATA_W-1:REQ_W];
    end
    if (cmd_i.exec) begin
      ok_q <= cmd_i.ok;
    end
    if (cmd_i.load_out) begin
      out_q <= {5'b0, full, empty,
                empty ? EMPTY_MARK : rear_rd_q,
                empty ? EMPTY_MARK : front_rd_q,
                ok_q};
    end
  end

  assign status_o.req      = req_q;
  assign status_o.full     = full;
  assign status_o.empty    = empty;
  assign status_o.out_free = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// File: hdl/bounded_deque.sv
// Sequence: the sequencer runs capture, ring update, slot read and hand-over
// one after the other and takes no new request until the hand-over is done;
// the last step waits while the output register is still held by the sink,
// and the result word is valid once the hand-over has loaded that register.
// Reset clears the head index, entry count and output valid, and sets the
// capacity to 16; slot contents are left as they are until written.
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of 32-bit signed values with a programmable capacity.
// ----------------------------------------------------------------------------
module bounded_deque #(
  parameter int unsigned MAX_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Capacity register write port.
  input  logic                           cfg_we_i,
  input  logic [dq_pkg::CAP_W-1:0]       cfg_wdata_i,
  // Request stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // Fields from bit 0: req_type[2:0], value[34:3], zero fill to 40 bits.
  input  logic [dq_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // Result stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // Fields from bit 0: ok[0], front_value[32:1], rear_value[64:33],
  // is_empty[65], is_full[66], zero fill to 72 bits.
  output logic [dq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import dq_pkg::*;

  // The controller sequences each request word through the datapath. The
  // datapath keeps the entries in a ring addressed by a head index and a
  // count, so a push or pop at either end moves only a pointer. A refused
  // request leaves the ring as it was and still produces a result word.
  dq_cmd_t    cmd;
  dq_status_t status;

  dq_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  // The output register sits in the datapath, so the next request can be
  // taken and worked on while the previous result word waits for the sink.
  dq_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

// File: tb/sv/tb_bounded_deque.sv
// ----------------------------------------------------------------------------
// tb_bounded_deque
// Self-checking bench for the bounded deque: a directed part covers the
// empty, full, refused, unknown-code and capacity corner cases; random
// traffic under several capacities follows, with random source gaps and
// sink stalls. A local ring model predicts every result word.
// ----------------------------------------------------------------------------
module tb_bounded_deque;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned MAX_REPORTS = 10;
  // Request codes the block does not know; they must leave the state alone.
  localparam logic [REQ_W-1:0] REQ_BAD_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_BAD_LAST  = 3'd7;

  typedef struct {
    logic              ok;
    logic [DATA_W-1:0] front;
    logic [DATA_W-1:0] rear;
    logic              empty;
    logic              full;
  } deque_view_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CAP_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  bounded_deque #(
    .MAX_DEPTH(RING_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Local copy of the ring: contents, head, fill level and capacity register.
  logic [DATA_W-1:0] ring_slots [RING_DEPTH];
  int unsigned       ring_head = 0;
  int unsigned       ring_count = 0;
  logic [CAP_W-1:0]  ring_capacity = CAP_RESET;

  deque_view_t pending_results [$];

  bit          src_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;
  int unsigned error_count = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned pushes_refused = 0;
  int unsigned pops_refused = 0;
  int unsigned unknown_codes = 0;
  int unsigned capacity_writes = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned capacity_limit();
    return (ring_capacity > RING_DEPTH) ? RING_DEPTH : int'(ring_capacity);
  endfunction

  // Applies one request to the local ring and returns the word it should give.
  function automatic deque_view_t deque_apply(input logic [REQ_W-1:0] req,
                                              input logic [DATA_W-1:0] value);
    deque_view_t view;
    int unsigned limit;
    bit          was_full;
    bit          was_empty;
    limit     = capacity_limit();
    was_full  = ring_count >= limit;
    was_empty = ring_count == 0;
    view.ok   = 1'b0;
    case (req)
      REQ_PUSH_FRONT: begin
        if (!was_full) begin
          ring_head = (ring_head + RING_DEPTH - 1) % RING_DEPTH;
          ring_slots[ring_head] = value;
          ring_count++;
          view.ok = 1'b1;
        end else begin
          pushes_refused++;
        end
      end
      REQ_PUSH_BACK: begin
        if (!was_full) begin
          ring_slots[(ring_head + ring_count) % RING_DEPTH] = value;
          ring_count++;
          view.ok = 1'b1;
        end else begin
          pushes_refused++;
        end
      end
      REQ_POP_FRONT: begin
        if (!was_empty) begin
          ring_head = (ring_head + 1) % RING_DEPTH;
          ring_count--;
          view.ok = 1'b1;
        end else begin
          pops_refused++;
        end
      end
      REQ_POP_BACK: begin
        if (!was_empty) begin
          ring_count--;
          view.ok = 1'b1;
        end else begin
          pops_refused++;
        end
      end
      REQ_QUERY: view.ok = 1'b1;
      default: unknown_codes++;
    endcase
    view.empty = ring_count == 0;
    view.full  = ring_count >= limit;
    view.front = view.empty ? EMPTY_MARK : ring_slots[ring_head];
    view.rear  = view.empty ? EMPTY_MARK :
                 ring_slots[(ring_head + ring_count - 1) % RING_DEPTH];
    return view;
  endfunction

  // Called right after a rising edge; returns right after the accepting edge.
  // The valid is only lowered when a gap follows, so it never toggles twice
  // within one time step.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] value);
    int unsigned gap;
    gap = src_gaps_on ? idle_length() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TDATA_W - REQ_W - DATA_W){1'b0}}, value, req};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(deque_apply(req, value));
    requests_sent++;
  endtask

  // Holds the source back until every outstanding word has come out.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    ring_capacity = cap;
    capacity_writes++;
    cfg_we_i <= 1'b0;
  endtask

  function automatic void compare_field(input string field, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("result %0d: %s expected %h, got %h", results_seen, field, want, got);
    end
  endfunction

  task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
    deque_view_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("result %0d: word %h arrived with nothing outstanding", results_seen, word);
      return;
    end
    want = pending_results.pop_front();
    compare_field("ok", DATA_W'(want.ok), DATA_W'(word[0]));
    compare_field("front_value", want.front, word[32:1]);
    compare_field("rear_value", want.rear, word[64:33]);
    compare_field("is_empty", DATA_W'(want.empty), DATA_W'(word[65]));
    compare_field("is_full", DATA_W'(want.full), DATA_W'(word[66]));
  endtask

  // Result side: samples at each rising edge, then decides the next ready.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_result(m_axis_tdata_o);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (sink_stalls_on && $urandom_range(0, 3) == 0) stall_left = idle_length();
      end
    end
  end

  // Straight out of reset: empty queries, refused pops and unknown codes.
  task automatic test_reset_state();
    send_request(REQ_QUERY, 32'h1234_5678);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_POP_BACK, '1);
    for (int code = REQ_BAD_FIRST; code <= REQ_BAD_LAST; code++)
      send_request(REQ_W'(code), $urandom);
  endtask

  // Extreme values through a two-entry deque, including a refused push.
  task automatic test_extremes_and_full();
    write_capacity(CAP_W'(2));
    send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_BACK, 32'h8000_0000);
    send_request(REQ_PUSH_BACK, 32'h5555_5555);
    send_request(REQ_QUERY, 32'hAAAA_AAAA);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_POP_FRONT, '0);
  endtask

  // A capacity of zero refuses all pushes and reads as both empty and full.
  task automatic test_zero_capacity();
    write_capacity('0);
    send_request(REQ_PUSH_FRONT, '1);
    send_request(REQ_PUSH_BACK, 32'h0000_0001);
    send_request(REQ_QUERY, '0);
  endtask

  // Shrinking the capacity below the fill level keeps the entries held.
  task automatic test_capacity_shrink();
    write_capacity(CAP_W'(3));
    send_request(REQ_PUSH_BACK, '0);
    send_request(REQ_PUSH_BACK, '1);
    send_request(REQ_PUSH_FRONT, 32'h0F0F_F0F0);
    write_capacity(CAP_W'(1));
    send_request(REQ_PUSH_FRONT, 32'hDEAD_0001);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_QUERY, '0);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_POP_BACK, '0);
  endtask

  // Random traffic that swings between filling and draining, so both the
  // full and the empty boundary are crossed many times.
  task automatic test_random_traffic(input int unsigned n_items, input logic [CAP_W-1:0] cap,
                                     input bit src_gaps, input bit sink_stalls);
    bit               filling;
    int unsigned      pick;
    logic [REQ_W-1:0] req;
    write_capacity(cap);
    src_gaps_on    = src_gaps;
    sink_stalls_on = sink_stalls;
    filling        = 1'b1;
    repeat (n_items) begin
      if (ring_count == 0) filling = 1'b1;
      else if (ring_count >= capacity_limit() && $urandom_range(0, 2) == 0) filling = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        req = REQ_W'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST));
      end else if (pick < 10) begin
        req = REQ_QUERY;
      end else if (($urandom_range(0, 3) != 0) == filling) begin
        req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
      end else begin
        req = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
      end
      send_request(req, $urandom);
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_extremes_and_full();
    test_zero_capacity();
    test_capacity_shrink();

    test_random_traffic(160, CAP_W'(31), 1'b1, 1'b1);
    test_random_traffic(160, CAP_W'(16), 1'b0, 1'b1);
    test_random_traffic(100, CAP_W'(1), 1'b1, 1'b1);
    test_random_traffic(160, CAP_W'(17), 1'b1, 1'b0);
    test_random_traffic(60, '0, 1'b1, 1'b1);
    test_random_traffic(160, CAP_W'(5), 1'b0, 1'b0);
    test_random_traffic(140, CAP_W'($urandom_range(2, 15)), 1'b1, 1'b1);
    test_random_traffic(140, CAP_W'(16), 1'b1, 1'b1);

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d requests over %0d capacity settings; %0d result words checked.",
             requests_sent, capacity_writes, results_seen);
    $display("Refused: %0d pushes when full, %0d pops when empty; %0d unknown codes.",
             pushes_refused, pops_refused, unknown_codes);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_bounded_deque passed");
    end else begin
      $display("tb_bounded_deque failed");
    end
    $finish;
  end

  // Far beyond the slowest legal run, even with every gap and stall at its longest.
  initial begin : watchdog
    #4_000_000;
    $display("tb_bounded_deque failed");
    $finish;
  end

endmodule
